[design/tgarle_pkg.sv]
// shared types and constants of the tga run-length pixel decoder
// no dependencies; imported by tga_rle_pixel_decoder_unit
`default_nettype none

package tgarle_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W       = 13;
  localparam int PIX_W       = 32;
  localparam int IDX_W       = 24;
  localparam int CNT_W       = 7;
  localparam int OUT_TDATA_W = 64;

  localparam int RUN_FLAG_BIT = 7;

  typedef enum logic [1:0] {
    REG_WIDTH      = 2'd0,
    REG_HEIGHT     = 2'd1,
    REG_ORIENT     = 2'd2,
    REG_COMPRESSED = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OR_ROWS_FLIPPED = 2'd0,
    OR_REVERSED     = 2'd1,
    OR_AS_STORED    = 2'd2,
    OR_COLS_FLIPPED = 2'd3
  } orient_t;

  typedef enum logic [2:0] {
    ST_PROD = 3'b001,
    ST_BASE = 3'b010,
    ST_RUN  = 3'b100
  } dec_state_t;

  // file byte order b0 b1 b2 b3 becomes b2 b1 b0 b3
  function automatic logic [PIX_W-1:0] swap_rb(input logic [PIX_W-1:0] p);
    swap_rb = {p[31:24], p[7:0], p[15:8], p[23:16]};
  endfunction

endpackage

`default_nettype wire

[design/tga_rle_pixel_decoder_unit.sv]
// tga run-length pixel decoder, 32-bit pixels, with orientation index remap
// depends on tgarle_pkg
//
// usage:
//   in_*  : one request per cycle while in_tready is high; in_tuser is the action
//           (0 data byte, 1 drain tick), in_tdata the byte
//   out_* : one result per produced pixel; out_tlast marks the final pixel
//   cfg_* : register writes (index 0 width, 1 height, 2 orientation,
//           3 compressed); each write restarts the decoder
// a result appears on out_* in the cycle after the request that caused it
// throughput: one request per cycle while in_tready is high; the destination index is kept
//   in a register, stepped by +-1 or at a row end by +-(2*width-1); no multiply in the request path
// after reset or a register write the block passes through ST_PROD and ST_BASE (in_tready
//   low) to form width*height in the multiplier and load the starting index
// when the receiver stalls, the result register holds and in_tready drops
//   only while a result is waiting and out_tready is low
`default_nettype none

module tga_rle_pixel_decoder_unit
  import tgarle_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,     // [7:0] data_byte
  input  wire logic                   in_tuser,     // [0] action
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,    // [31:0] pixel_word, [55:32] out_index,
                                                    // [56] run_pending, [63:57] zero
  output logic                        out_tlast,    // last_pixel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [CFG_W-1:0] width_cfg_r, height_cfg_r;
  orient_t          orient_r;
  logic             compressed_r;

  // decoder state
  dec_state_t       state_r, state_nxt;
  logic             in_packet_r, in_packet_nxt;
  logic             is_run_r, is_run_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [1:0]       bpos_r, bpos_nxt;
  logic [PIX_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0] repeats_r, repeats_nxt;
  logic [WW-1:0]    col_r, col_nxt;
  logic [HW-1:0]    row_r, row_nxt;
  logic             done_r, done_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] prod_r;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_word_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_pend_r, out_last_r;

  logic             in_acc, cfg_acc, emit, row_end, last;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [WW+HW-1:0] prod_full;
  logic [IDX_W-1:0] w_ext, w2_ext, base_idx;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (state_r == ST_RUN) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // effective dimensions: zero means one, saturate at the maximum
  always_comb begin
    if (width_cfg_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_cfg_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(height_cfg_r) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_cfg_r);
    end
  end

  assign prod_full = (WW+HW)'(eff_w) * (WW+HW)'(eff_h);
  assign w_ext     = IDX_W'(eff_w);
  assign w2_ext    = IDX_W'({eff_w, 1'b0});

  // index of the first stored pixel
  always_comb begin
    case (orient_r)
      OR_ROWS_FLIPPED: base_idx = prod_r - w_ext;
      OR_REVERSED:     base_idx = prod_r - IDX_W'(1);
      OR_AS_STORED:    base_idx = '0;
      OR_COLS_FLIPPED: base_idx = w_ext - IDX_W'(1);
      default:         base_idx = '0;
    endcase
  end

  assign row_end = (col_r == eff_w - WW'(1));
  assign last    = row_end && (row_r == eff_h - HW'(1));

  always_comb begin
    state_nxt     = state_r;
    in_packet_nxt = in_packet_r;
    is_run_nxt    = is_run_r;
    left_nxt      = left_r;
    bpos_nxt      = bpos_r;
    shift_nxt     = shift_r;
    repeats_nxt   = repeats_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    emit          = 1'b0;

    case (state_r)
      ST_PROD: state_nxt = ST_BASE;
      ST_BASE: begin
        state_nxt = ST_RUN;
        idx_nxt   = base_idx;
      end
      ST_RUN:  state_nxt = ST_RUN;
      default: state_nxt = ST_PROD;
    endcase

    if (in_acc && !done_r) begin
      if (in_tuser) begin
        if (repeats_r != '0) begin
          repeats_nxt = repeats_r - CNT_W'(1);
          emit        = 1'b1;
        end
      end else if (repeats_r == '0) begin
        if (compressed_r && !in_packet_r) begin
          // packet header
          in_packet_nxt = 1'b1;
          is_run_nxt    = in_tdata[RUN_FLAG_BIT];
          left_nxt      = in_tdata[CNT_W-1:0];
          bpos_nxt      = 2'd0;
        end else begin
          shift_nxt[bpos_r*8 +: 8] = in_tdata;
          if (bpos_r != 2'd3) begin
            bpos_nxt = bpos_r + 2'd1;
          end else begin
            bpos_nxt = 2'd0;
            emit     = 1'b1;
            if (compressed_r) begin
              if (is_run_r) begin
                repeats_nxt   = left_r;
                in_packet_nxt = 1'b0;
                left_nxt      = '0;
              end else if (left_r == '0) begin
                in_packet_nxt = 1'b0;
              end else begin
                left_nxt = left_r - CNT_W'(1);
              end
            end
          end
        end
      end
    end

    if (emit) begin
      case (orient_r)
        OR_ROWS_FLIPPED: idx_nxt = row_end ? idx_r + IDX_W'(1) - w2_ext : idx_r + IDX_W'(1);
        OR_REVERSED:     idx_nxt = idx_r - IDX_W'(1);
        OR_AS_STORED:    idx_nxt = idx_r + IDX_W'(1);
        OR_COLS_FLIPPED: idx_nxt = row_end ? idx_r - IDX_W'(1) + w2_ext : idx_r - IDX_W'(1);
        default:         idx_nxt = idx_r;
      endcase
      if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + HW'(1);
      end else begin
        col_nxt = col_r + WW'(1);
      end
      if (last) begin
        done_nxt    = 1'b1;
        repeats_nxt = '0;
      end
    end

    // a register write restarts the decoder
    if (cfg_acc) begin
      state_nxt     = ST_PROD;
      in_packet_nxt = 1'b0;
      is_run_nxt    = 1'b0;
      left_nxt      = '0;
      bpos_nxt      = 2'd0;
      shift_nxt     = '0;
      repeats_nxt   = '0;
      col_nxt       = '0;
      row_nxt       = '0;
      done_nxt      = 1'b0;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= CFG_W'(1);
      height_cfg_r <= CFG_W'(1);
      orient_r     <= OR_ROWS_FLIPPED;
      compressed_r <= 1'b1;
      state_r      <= ST_PROD;
      in_packet_r  <= 1'b0;
      is_run_r     <= 1'b0;
      left_r       <= '0;
      bpos_r       <= 2'd0;
      shift_r      <= '0;
      repeats_r    <= '0;
      col_r        <= '0;
      row_r        <= '0;
      done_r       <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_reg_t'(cfg_index))
          REG_WIDTH:      width_cfg_r  <= cfg_data;
          REG_HEIGHT:     height_cfg_r <= cfg_data;
          REG_ORIENT:     orient_r     <= orient_t'(cfg_data[1:0]);
          REG_COMPRESSED: compressed_r <= cfg_data[0];
          default:        compressed_r <= compressed_r;
        endcase
      end
      state_r     <= state_nxt;
      in_packet_r <= in_packet_nxt;
      is_run_r    <= is_run_nxt;
      left_r      <= left_nxt;
      bpos_r      <= bpos_nxt;
      shift_r     <= shift_nxt;
      repeats_r   <= repeats_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      done_r      <= done_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= IDX_W'(prod_full);
    if (emit) begin
      out_word_r <= swap_rb(shift_nxt);
      out_idx_r  <= idx_r;
      out_pend_r <= (repeats_nxt != '0);
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-PIX_W-IDX_W-1){1'b0}}, out_pend_r, out_idx_r, out_word_r};
  assign out_tlast  = out_last_r;

  // checks
  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("decoder state not one-hot");

  a_no_accept_settling: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !in_tready)
    else $error("request taken before start index loaded");

  a_last_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> !out_tdata[PIX_W+IDX_W])
    else $error("final pixel reports pending run copies");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last && !cfg_acc) |=> (done_r && repeats_r == '0))
    else $error("image not closed after final pixel");

  a_done_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !emit)
    else $error("pixel produced after image end");

endmodule

`default_nettype wire
